// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
// Depends on nothing; each macro takes a label, clock, reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/cst_pkg.sv =====
// Shared types and constants of the command tokenizer.
// Depends on nothing; imported by every module of the block.
package cst_pkg;

   localparam int MAX_TOKEN_CHARS_DEF = 32;
   localparam int MAX_ARGS_DEF        = 8;

   localparam int BYTE_W   = 8;
   localparam int SLOT_W   = 4;
   localparam int OFFSET_W = 5;
   localparam int ERROR_W  = 2;
   localparam int COUNT_W  = 4;

   localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

   typedef enum logic [2:0] {
      PH_NAME   = 3'd0,
      PH_ARGS   = 3'd1,
      PH_STRING = 3'd2,
      PH_ERROR  = 3'd3,
      PH_END    = 3'd4
   } phase_type;

   typedef enum logic [ERROR_W-1:0] {
      ERR_NONE     = 2'd0,
      ERR_OVERFLOW = 2'd1,
      ERR_ARGS     = 2'd2
   } error_type;

   // One result item as it leaves the tokenizer step logic.
   typedef struct packed {
      logic                write_valid;
      logic [SLOT_W-1:0]   write_slot;
      logic [OFFSET_W-1:0] write_offset;
      logic [BYTE_W-1:0]   write_char;
      error_type           error_code;
      logic                command_done;
      logic                command_ok;
      logic [COUNT_W-1:0]  arg_count;
   } rsp_type;

endpackage

// ===== rtl/cst_step.sv =====
// Combinational next-state and result logic for one received byte.
// Depends on cst_pkg for phase codes, character constants and the result struct.
module cst_step import cst_pkg::*; #(
   parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF,
   parameter int MAX_ARGS        = MAX_ARGS_DEF,
   localparam int OFF_W          = $clog2(MAX_TOKEN_CHARS + 1),
   localparam int AI_W           = $clog2(MAX_ARGS + 2)
) (
   input  logic [BYTE_W-1:0] rx_byte,
   input  phase_type         phase,
   input  logic [OFF_W-1:0]  offset,
   input  logic [AI_W-1:0]   arg_index,
   input  logic              first_nonempty,
   output phase_type         phase_next,
   output logic [OFF_W-1:0]  offset_next,
   output logic [AI_W-1:0]   arg_index_next,
   output logic              first_nonempty_next,
   output logic              result_valid,
   output rsp_type           result
);

   always_comb begin
      phase_type        ph;
      logic [OFF_W-1:0] off;
      logic [OFF_W-1:0] woff;
      logic [AI_W-1:0]  ai;
      logic [AI_W-1:0]  wslot;
      logic [BYTE_W-1:0] wch;
      logic             wv;
      logic             fl;
      logic             done;
      logic             ok;
      error_type        err;

      ph    = phase;
      off   = offset;
      ai    = arg_index;
      fl    = first_nonempty;
      wv    = 1'b0;
      wslot = '0;
      woff  = '0;
      wch   = '0;
      done  = 1'b0;
      ok    = 1'b0;
      err   = ERR_NONE;

      // A token that has filled up is caught before the byte is looked at.
      if (off >= OFF_W'(MAX_TOKEN_CHARS)) begin
         err = ERR_OVERFLOW;
         off = '0;
         ph  = PH_ERROR;
      end

      case (ph)
         PH_NAME: begin
            wv   = 1'b1;
            woff = off;
            if (rx_byte != CH_LPAREN) begin
               wch = rx_byte;
               off = off + OFF_W'(1);
            end else begin
               off = '0;
               ai  = '0;
               ph  = PH_ARGS;
            end
         end
         PH_ARGS: begin
            case (rx_byte)
               CH_COMMA: begin
                  wv    = 1'b1;
                  wslot = ai + AI_W'(1);
                  woff  = off;
                  off   = '0;
                  ai    = ai + AI_W'(1);
                  if (ai > AI_W'(MAX_ARGS)) begin
                     ph  = PH_ERROR;
                     err = ERR_ARGS;
                  end
               end
               CH_RPAREN: begin
                  wv    = 1'b1;
                  wslot = ai + AI_W'(1);
                  woff  = off;
                  // The terminator itself may land on the first argument's first byte.
                  if (ai == '0 && off == '0) begin
                     fl = 1'b0;
                  end
                  off  = off + OFF_W'(1);
                  ai   = fl ? ai + AI_W'(1) : '0;
                  ph   = PH_END;
                  done = 1'b1;
                  ok   = 1'b1;
               end
               CH_QUOTE: begin
                  ph = PH_STRING;
               end
               CH_SPACE, CH_TAB: begin
               end
               default: begin
                  wv    = 1'b1;
                  wslot = ai + AI_W'(1);
                  woff  = off;
                  wch   = rx_byte;
                  off   = off + OFF_W'(1);
               end
            endcase
         end
         PH_STRING: begin
            if (rx_byte != CH_QUOTE) begin
               wv    = 1'b1;
               wslot = ai + AI_W'(1);
               woff  = off;
               wch   = rx_byte;
               off   = off + OFF_W'(1);
            end else begin
               ph = PH_ARGS;
            end
         end
         PH_ERROR: begin
            // The closing parenthesis ends a discarded command; the offset is kept.
            if (rx_byte == CH_RPAREN) begin
               ai   = '0;
               wv   = 1'b1;
               ph   = PH_END;
               done = 1'b1;
            end
         end
         default: begin
            if (!(rx_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) begin
               ph   = PH_NAME;
               wv   = 1'b1;
               woff = '0;
               wch  = rx_byte;
               off  = OFF_W'(1);
            end
         end
      endcase

      // Any write at the first argument's first byte refreshes the non-empty flag.
      if (wv && wslot == AI_W'(1) && woff == '0) begin
         fl = (wch != '0);
      end

      phase_next          = ph;
      offset_next         = off;
      arg_index_next      = ai;
      first_nonempty_next = fl;
      result_valid        = wv || (err != ERR_NONE) || done;

      result.write_valid  = wv;
      result.write_slot   = SLOT_W'(wslot);
      result.write_offset = OFFSET_W'(woff);
      result.write_char   = wch;
      result.error_code   = err;
      result.command_done = done;
      result.command_ok   = ok;
      result.arg_count    = done ? COUNT_W'(ai) : '0;
   end

endmodule

// ===== rtl/cst_out_reg.sv =====
// Result register that holds one item until the receiver takes it.
// Depends on cst_pkg for the result struct.
module cst_out_reg import cst_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  logic    load_valid,
   input  rsp_type load_data,
   input  logic    out_ready,
   output logic    out_valid,
   output logic    free,
   output rsp_type out_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // The register can take a new item whenever it is empty or being drained.
   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = load_valid;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/call_syntax_command_tokenizer.sv =====
// Top level of the call-syntax command tokenizer.
// Depends on cst_pkg, cst_step and cst_out_reg.
//
// The block reads a byte stream of commands written as name(arg,arg,"text").
// Each byte comes in as one item on the req_ channel (req_tdata[7:0]). A byte
// that stores a character or terminator, raises an error or ends a command
// gives one item on the rsp_ channel; other bytes (whitespace, quotes, bytes
// dropped after an error) give none. The character offset carries from one
// command to the next, so an overlong run raises an overflow error even at
// the start of a new command.
// A result item is registered and shown in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the result register is free; the parse
// state is updated by a single pass of step logic at the accepting edge, and a
// single result register parts the two sides.
// When the receiver stalls, the result register holds its item and req_tready
// drops, so no further byte is taken until the item has gone; req_tready stays
// high while the register is empty or drains in the same cycle.
// Reset (synchronous, active high) puts the parser in the idle phase that
// skips leading whitespace, clears the offset, argument index and first
// argument flag, and empties the result register.
module call_syntax_command_tokenizer import cst_pkg::*; #(
   parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF,
   parameter int MAX_ARGS        = MAX_ARGS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] write_slot, [8:4] write_offset,
                                    // [16:9] write_char, [17] command_ok,
                                    // [21:18] arg_count, [23:22] zero
   output logic        rsp_tlast,   // command_done
   output logic [2:0]  rsp_tuser    // [0] write_valid, [2:1] error_code
);

   localparam int OFF_W = $clog2(MAX_TOKEN_CHARS + 1);
   localparam int AI_W  = $clog2(MAX_ARGS + 2);

   // Parse state, updated only at an accepting edge.
   phase_type        phase_ff;
   phase_type        phase_in;
   logic [OFF_W-1:0] offset_ff;
   logic [OFF_W-1:0] offset_in;
   logic [AI_W-1:0]  arg_index_ff;
   logic [AI_W-1:0]  arg_index_in;
   logic             first_nonempty_ff;
   logic             first_nonempty_in;

   logic    accept;
   logic    step_valid;
   rsp_type step_result;
   rsp_type out_result;

   assign accept = req_tvalid && req_tready;

   cst_step #(
      .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS),
      .MAX_ARGS       (MAX_ARGS)
   ) u_step (
      .rx_byte            (req_tdata),
      .phase              (phase_ff),
      .offset             (offset_ff),
      .arg_index          (arg_index_ff),
      .first_nonempty     (first_nonempty_ff),
      .phase_next         (phase_in),
      .offset_next        (offset_in),
      .arg_index_next     (arg_index_in),
      .first_nonempty_next(first_nonempty_in),
      .result_valid       (step_valid),
      .result             (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_END;
         offset_ff         <= '0;
         arg_index_ff      <= '0;
         first_nonempty_ff <= 1'b0;
      end else if (accept) begin
         phase_ff          <= phase_in;
         offset_ff         <= offset_in;
         arg_index_ff      <= arg_index_in;
         first_nonempty_ff <= first_nonempty_in;
      end
   end

   cst_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_valid(step_valid),
      .load_data (step_result),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .free      (req_tready),
      .out_data  (out_result)
   );

   assign rsp_tdata = {2'b00,
                       out_result.arg_count,
                       out_result.command_ok,
                       out_result.write_char,
                       out_result.write_offset,
                       out_result.write_slot};
   assign rsp_tlast = out_result.command_done;
   assign rsp_tuser = {out_result.error_code, out_result.write_valid};

endmodule

// ===== rtl/cst_checker.sv =====
// Port-level checker for the command tokenizer, bound to the top level.
// Depends on assert_macros.svh for the assertion macros and cst_pkg for error codes.
`include "assert_macros.svh"

module cst_checker import cst_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [2:0]  rsp_tuser
);

   // A stalled result item stays on the channel.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // While a result item is stalled, no new byte may be taken.
   `ASSERT_IMPLY(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

   // A valid command is always reported at a command end.
   `ASSERT_IMPLY(a_ok_needs_done, clock, reset, rsp_tvalid && rsp_tdata[17], rsp_tlast)

   // Without a write, slot, offset and character read as zero.
   `ASSERT_IMPLY(a_no_write_zero, clock, reset, rsp_tvalid && !rsp_tuser[0],
      rsp_tdata[16:0] == 17'd0)

   // The error code of a result item is always one of the defined codes.
   `ASSERT_IMPLY(a_error_code_legal, clock, reset, rsp_tvalid, rsp_tuser[2:1] <= ERR_ARGS)

endmodule

bind call_syntax_command_tokenizer cst_checker u_cst_checker (.*);
